/* src/lru_cache_charge_evict_defines.svh */
// Assertion macros for the lru cache block
`ifndef LRU_CACHE_CHARGE_EVICT_DEFINES_SVH
`define LRU_CACHE_CHARGE_EVICT_DEFINES_SVH
// check that a condition implies a consequence on the same edge
`define LCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lce check failed");
// check that a condition implies a consequence on the next edge
`define LCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lce check failed");
`endif

/* src/lce_pkg.sv */
package lce_pkg;
	localparam int ENTRIES  = 16;
	localparam int REF_BITS = 8;
	localparam int IDX_W    = $clog2(ENTRIES + 1);
	localparam int USAGE_W  = 20;
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 32;
	localparam int CHG_W    = 16;
	localparam logic [IDX_W-1:0] NIL = IDX_W'(ENTRIES);
	localparam logic [REF_BITS-1:0] REF_MAX = '1;

	localparam logic [1:0] FN_INSERT  = 2'd0;
	localparam logic [1:0] FN_LOOKUP  = 2'd1;
	localparam logic [1:0] FN_RELEASE = 2'd2;

	localparam logic [3:0] ST_INSERTED = 4'd0;
	localparam logic [3:0] ST_PRESENT  = 4'd1;
	localparam logic [3:0] ST_FULL     = 4'd2;
	localparam logic [3:0] ST_HIT      = 4'd3;
	localparam logic [3:0] ST_MISS     = 4'd4;
	localparam logic [3:0] ST_RELEASED = 4'd5;
	localparam logic [3:0] ST_REL_ERR  = 4'd6;
	localparam logic [3:0] ST_REF_LIM  = 4'd7;
	localparam logic [3:0] ST_EVICTED  = 4'd8;
endpackage

/* src/lru_cache_charge_evict.sv */
// Channel   | handshake            | payload
// in        | in_valid / in_ready  | func, key, value_tag, charge
// out       | out_valid / out_ready| status, key_out, value_out, usage_out, last
// cfg       | cfg_we               | cfg_wdata (capacity)
//
// Steps per item with the receiver ready: lookup, release, miss, present and
// full go decide, beat, idle; a release that puts the entry back on the LRU
// tail adds an append step before the beat. Insert into a free slot goes
// decide, fill, check, beat, idle. An eviction is evict, last flag, beat, then
// fill or recheck; a full table evicts once first. Key match is parallel.
// Reset clears valid bits, list head/tail and usage; slot payload is not reset.
// A stalled output beat holds the sequencer; input is taken only when idle.
module lru_cache_charge_evict (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [lce_pkg::KEY_W-1:0]    key,
	input  logic [lce_pkg::VAL_W-1:0]    value_tag,
	input  logic [lce_pkg::CHG_W-1:0]    charge,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [3:0]                   status,
	output logic [lce_pkg::KEY_W-1:0]    key_out,
	output logic [lce_pkg::VAL_W-1:0]    value_out,
	output logic [lce_pkg::USAGE_W-1:0]  usage_out,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [lce_pkg::USAGE_W-1:0]  cfg_wdata
);
	localparam int IW = lce_pkg::IDX_W;
	localparam int SW = $clog2(lce_pkg::ENTRIES);
	localparam int USAGE_W = lce_pkg::USAGE_W;
	localparam logic [lce_pkg::REF_BITS-1:0] REF_ONE = lce_pkg::REF_BITS'(1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1; // decide op after match
	localparam logic [2:0] S_EVICT = 3'd2; // unlink head, load evict beat
	localparam logic [2:0] S_FILL  = 3'd3; // write new entry, append
	localparam logic [2:0] S_CHECK = 3'd4; // over capacity?
	localparam logic [2:0] S_OUT   = 3'd5; // wait for output beat
	localparam logic [2:0] S_APP   = 3'd6; // append after release
	localparam logic [2:0] S_ELAST = 3'd7; // last flag of an evict beat

	logic [2:0] state_q, ret_q;

	logic [lce_pkg::ENTRIES-1:0]        valid_q;
	logic [lce_pkg::KEY_W-1:0]          skey_q [lce_pkg::ENTRIES];
	logic [lce_pkg::VAL_W-1:0]          sval_q [lce_pkg::ENTRIES];
	logic [lce_pkg::CHG_W-1:0]          schg_q [lce_pkg::ENTRIES];
	logic [lce_pkg::REF_BITS-1:0]       sref_q [lce_pkg::ENTRIES];
	logic [IW-1:0]                      next_q [lce_pkg::ENTRIES];
	logic [IW-1:0]                      prev_q [lce_pkg::ENTRIES];
	logic [IW-1:0]                      head_q, tail_q;
	logic [lce_pkg::USAGE_W-1:0]        usage_q, cap_q;

	logic [1:0]                         func_q;
	logic [lce_pkg::KEY_W-1:0]          key_q;
	logic [lce_pkg::VAL_W-1:0]          val_q;
	logic [lce_pkg::CHG_W-1:0]          chg_q;
	logic [SW-1:0]                      hidx_q, fidx_q;
	logic                               evicted_q;

	logic                               ov_q;
	logic [3:0]                         ost_q;
	logic [lce_pkg::KEY_W-1:0]          okey_q;
	logic [lce_pkg::VAL_W-1:0]          oval_q;
	logic                               olast_q;

	// parallel match and free-slot search
	logic          hit_c, free_c;
	logic [SW-1:0] hidx_c, fidx_c;
	always_comb begin
		hit_c = 1'b0; hidx_c = '0; free_c = 1'b0; fidx_c = '0;
		for (int i = lce_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && skey_q[i] == key_q) begin
				hit_c = 1'b1; hidx_c = SW'(i);
			end
			if (!valid_q[i]) begin
				free_c = 1'b1; fidx_c = SW'(i);
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign status    = ost_q;
	assign key_out   = okey_q;
	assign value_out = oval_q;
	assign usage_out = usage_q;
	assign last      = olast_q;

	logic [SW-1:0] hd;
	assign hd = head_q[SW-1:0];
	// usage plus the pending charge, saturated
	logic [lce_pkg::USAGE_W:0] usum;
	assign usum = {1'b0, usage_q} + (lce_pkg::USAGE_W+1)'(chg_q);
	logic [lce_pkg::USAGE_W-1:0] usat;
	assign usat = usum[lce_pkg::USAGE_W] ? '1 : usum[lce_pkg::USAGE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ret_q <= S_IDLE;
			valid_q <= '0; head_q <= lce_pkg::NIL; tail_q <= lce_pkg::NIL;
			usage_q <= '0; cap_q <= '0; ov_q <= 1'b0; evicted_q <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func; key_q <= key; val_q <= value_tag; chg_q <= charge;
						evicted_q <= 1'b0;
						state_q <= (func > lce_pkg::FN_RELEASE) ? S_IDLE : S_DEC;
					end
				end
				S_DEC: begin
					hidx_q <= hidx_c;
					case (func_q)
						lce_pkg::FN_INSERT: begin
							if (hit_c) begin
								ost_q <= lce_pkg::ST_PRESENT; okey_q <= '0; oval_q <= '0;
								olast_q <= 1'b1; ov_q <= 1'b1;
								state_q <= S_OUT; ret_q <= S_IDLE;
							end else if (free_c) begin
								fidx_q <= fidx_c;
								state_q <= S_FILL;
							end else if (head_q == lce_pkg::NIL) begin
								ost_q <= lce_pkg::ST_FULL; okey_q <= '0; oval_q <= '0;
								olast_q <= 1'b1; ov_q <= 1'b1;
								state_q <= S_OUT; ret_q <= S_IDLE;
							end else begin
								// no free slot: the LRU head makes room
								fidx_q <= hd;
								state_q <= S_EVICT; ret_q <= S_FILL;
							end
						end
						lce_pkg::FN_LOOKUP: begin
							ov_q <= 1'b1; state_q <= S_OUT; ret_q <= S_IDLE; olast_q <= 1'b1;
							if (!hit_c) begin
								ost_q <= lce_pkg::ST_MISS; okey_q <= '0; oval_q <= '0;
							end else begin
								okey_q <= skey_q[hidx_c]; oval_q <= sval_q[hidx_c];
								if (sref_q[hidx_c] == lce_pkg::REF_MAX) begin
									ost_q <= lce_pkg::ST_REF_LIM;
								end else begin
									ost_q <= lce_pkg::ST_HIT;
									sref_q[hidx_c] <= sref_q[hidx_c] + REF_ONE;
									if (sref_q[hidx_c] == '0) begin
										if (prev_q[hidx_c] == lce_pkg::NIL) head_q <= next_q[hidx_c];
										else next_q[prev_q[hidx_c][SW-1:0]] <= next_q[hidx_c];
										if (next_q[hidx_c] == lce_pkg::NIL) tail_q <= prev_q[hidx_c];
										else prev_q[next_q[hidx_c][SW-1:0]] <= prev_q[hidx_c];
									end
								end
							end
						end
						default: begin
							ret_q <= S_IDLE; okey_q <= '0; oval_q <= '0; olast_q <= 1'b1;
							if (!hit_c || sref_q[hidx_c] == '0) begin
								ost_q <= lce_pkg::ST_REL_ERR; ov_q <= 1'b1; state_q <= S_OUT;
							end else begin
								ost_q <= lce_pkg::ST_RELEASED;
								sref_q[hidx_c] <= sref_q[hidx_c] - REF_ONE;
								if (sref_q[hidx_c] == REF_ONE) begin
									state_q <= S_APP;
								end else begin
									ov_q <= 1'b1; state_q <= S_OUT;
								end
							end
						end
					endcase
				end
				S_APP: begin
					next_q[hidx_q] <= lce_pkg::NIL; prev_q[hidx_q] <= tail_q;
					if (tail_q == lce_pkg::NIL) head_q <= IW'(hidx_q);
					else next_q[tail_q[SW-1:0]] <= IW'(hidx_q);
					tail_q <= IW'(hidx_q);
					ov_q <= 1'b1; state_q <= S_OUT;
				end
				S_EVICT: begin
					// unlink list head, free it, report it
					head_q <= next_q[hd];
					if (next_q[hd] == lce_pkg::NIL) tail_q <= lce_pkg::NIL;
					else prev_q[next_q[hd][SW-1:0]] <= lce_pkg::NIL;
					valid_q[hd] <= 1'b0;
					usage_q <= (usage_q > USAGE_W'(schg_q[hd])) ?
						usage_q - USAGE_W'(schg_q[hd]) : '0;
					ost_q <= lce_pkg::ST_EVICTED; okey_q <= skey_q[hd];
					oval_q <= sval_q[hd]; evicted_q <= 1'b1;
					state_q <= S_ELAST;
				end
				S_ELAST: begin
					// final beat when nothing more will be evicted for this item:
					// before a fill, the fill's charge decides; else the recheck
					if (ret_q == S_FILL) olast_q <= !(usat > cap_q);
					else olast_q <= !(usage_q > cap_q && head_q != lce_pkg::NIL);
					ov_q <= 1'b1; state_q <= S_OUT;
				end
				S_FILL: begin
					valid_q[fidx_q] <= 1'b1; skey_q[fidx_q] <= key_q;
					sval_q[fidx_q] <= val_q; schg_q[fidx_q] <= chg_q; sref_q[fidx_q] <= '0;
					next_q[fidx_q] <= lce_pkg::NIL; prev_q[fidx_q] <= tail_q;
					if (tail_q == lce_pkg::NIL) head_q <= IW'(fidx_q);
					else next_q[tail_q[SW-1:0]] <= IW'(fidx_q);
					tail_q <= IW'(fidx_q);
					usage_q <= usat;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (usage_q > cap_q && head_q != lce_pkg::NIL) begin
						state_q <= S_EVICT; ret_q <= S_CHECK;
					end else if (!evicted_q) begin
						ost_q <= lce_pkg::ST_INSERTED; okey_q <= '0; oval_q <= '0;
						olast_q <= 1'b1; ov_q <= 1'b1; state_q <= S_OUT; ret_q <= S_IDLE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						ov_q <= 1'b0; state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* src/lce_checker.sv */
`include "lru_cache_charge_evict_defines.svh"
module lce_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] status,
	input logic       last
);
	`LCE_ASSERT_SAME(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`LCE_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status))
	`LCE_ASSERT_SAME(a_status_rng, clk, arst_n, out_valid, status <= lce_pkg::ST_EVICTED)
	`LCE_ASSERT_SAME(a_last_plain, clk, arst_n, out_valid && status != lce_pkg::ST_EVICTED, last)
endmodule

bind lru_cache_charge_evict lce_checker u_lce_checker (.*);
